@@ hdl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg: shared constants and types of the pitch PID controller
// Widths, the tip-over limit and the register index codes.
// ----------------------------------------------------------------------------
package ppc_pkg;

	localparam int ACC_WIDTH   = 32;
	localparam int PITCH_W     = 15;
	localparam int GAIN_W      = 16;
	localparam int LIMIT_W     = 15;
	localparam int DRIVE_W     = 16;
	localparam int ERR_W       = 16;
	localparam int DIFF_W      = ERR_W + 1;
	localparam int PROD_P_W    = GAIN_W + ERR_W;
	localparam int PROD_I_W    = GAIN_W + ACC_WIDTH;
	localparam int PROD_D_W    = GAIN_W + DIFF_W;
	localparam int SUM_W       = ACC_WIDTH + GAIN_W + 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int TIP_LIMIT   = 5760;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DRIVE_LIMIT
	} cfg_reg_t;

endpackage

@@ hdl/pitch_pid_with_cutoff.sv @@
// ----------------------------------------------------------------------------
// pitch_pid_with_cutoff: pitch PID controller with tip-over cutoff
// Computes a clamped drive command from measured and target pitch.
// ----------------------------------------------------------------------------
// Each input item is one control tick carrying measured and target pitch.
// The result item carries the drive command and the tip-over flag.
// Gains and the drive limit are written through the configuration channel
// (always ready); the user must write while no item is in flight, unchecked.
// The block is a three-stage pipeline: the first stage forms the error and,
// unless the item has tipped over, updates the saturating error sum and the
// previous error, the second forms the three gain products, and the third
// adds, shifts and clamps (zero on tip-over) into the output register. One
// item is taken in every cycle unless the output stalls. The first stage
// state is updated on acceptance, which allows the next item right behind.
// When the receiver stalls, the whole pipeline holds and in_ready drops only
// while the output register is full and not taken. Reset clears the gains,
// the limit, the error sum, the previous error and all stage valids.
// ----------------------------------------------------------------------------
module pitch_pid_with_cutoff
	import ppc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [PITCH_W-1:0]     measured_pitch,
	input  logic signed [PITCH_W-1:0]     target_pitch,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DRIVE_W-1:0]     drive,
	output logic                          tipped_over
);

	logic signed [GAIN_W-1:0]    gain_p_q;
	logic signed [GAIN_W-1:0]    gain_i_q;
	logic signed [GAIN_W-1:0]    gain_d_q;
	logic        [LIMIT_W-1:0]   drive_limit_q;
	logic signed [ACC_WIDTH-1:0] error_acc_q;
	logic signed [ERR_W-1:0]     prev_err_q;

	logic                        pipe_en;
	logic                        in_acc;
	logic                        tip_in;
	logic signed [ERR_W-1:0]     err_in;
	logic signed [ACC_WIDTH:0]   acc_wide;
	logic signed [ACC_WIDTH-1:0] acc_next;
	logic signed [DIFF_W-1:0]    diff_in;

	logic                        valid_s1;
	logic                        tip_s1;
	logic signed [ERR_W-1:0]     err_s1;
	logic signed [ACC_WIDTH-1:0] acc_s1;
	logic signed [DIFF_W-1:0]    diff_s1;

	logic                        valid_s2;
	logic                        tip_s2;
	logic signed [PROD_P_W-1:0]  prod_p_s2;
	logic signed [PROD_I_W-1:0]  prod_i_s2;
	logic signed [PROD_D_W-1:0]  prod_d_s2;

	logic signed [SUM_W-1:0]     sum_c;
	logic signed [SUM_W-1:0]     shifted_c;
	logic signed [SUM_W-1:0]     limit_pos_c;
	logic signed [SUM_W-1:0]     limit_neg_c;
	logic signed [SUM_W-1:0]     clamped_c;

	assign cfg_ready = 1'b1;
	assign pipe_en   = !out_valid || out_ready;
	assign in_ready  = pipe_en;
	assign in_acc    = in_valid && pipe_en;

	assign tip_in   = (measured_pitch > $signed(PITCH_W'(TIP_LIMIT)))
	               || (measured_pitch < -$signed(PITCH_W'(TIP_LIMIT)));
	assign err_in   = ERR_W'(measured_pitch) - ERR_W'(target_pitch);
	assign acc_wide = (ACC_WIDTH+1)'(error_acc_q) + (ACC_WIDTH+1)'(err_in);
	assign diff_in  = DIFF_W'(err_in) - DIFF_W'(prev_err_q);

	always_comb begin
		if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
			acc_next = acc_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
			                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			acc_next = acc_wide[ACC_WIDTH-1:0];
		end
	end

	always_comb begin
		sum_c       = SUM_W'(prod_p_s2) + SUM_W'(prod_i_s2) + SUM_W'(prod_d_s2);
		shifted_c   = sum_c >>> 4;
		limit_pos_c = $signed(SUM_W'(drive_limit_q));
		limit_neg_c = -limit_pos_c;
		if (tip_s2) begin
			clamped_c = '0;
		end else if (shifted_c > limit_pos_c) begin
			clamped_c = limit_pos_c;
		end else if (shifted_c < limit_neg_c) begin
			clamped_c = limit_neg_c;
		end else begin
			clamped_c = shifted_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			drive_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:      gain_p_q      <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_I:      gain_i_q      <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_D:      gain_d_q      <= $signed(cfg_data[GAIN_W-1:0]);
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_data[LIMIT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_acc_q <= '0;
			prev_err_q  <= '0;
		end else if (in_acc && !tip_in) begin
			error_acc_q <= acc_next;
			prev_err_q  <= err_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (pipe_en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tip_s1      <= tip_in;
			err_s1      <= err_in;
			acc_s1      <= acc_next;
			diff_s1     <= diff_in;
			tip_s2      <= tip_s1;
			prod_p_s2   <= gain_p_q * err_s1;
			prod_i_s2   <= gain_i_q * acc_s1;
			prod_d_s2   <= gain_d_q * diff_s1;
			drive       <= clamped_c[DRIVE_W-1:0];
			tipped_over <= tip_s2;
		end
	end

	a_tip_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tipped_over |-> drive == '0)
		else $error("tipped result carries a nonzero drive");

	a_tip_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && tip_in |=> $stable(error_acc_q) && $stable(prev_err_q))
		else $error("tipped item changed the PID state");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en && valid_s1 |=> valid_s1 && $stable(acc_s1))
		else $error("first stage item lost during a stall");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en && valid_s2 |=> valid_s2 && $stable(prod_i_s2))
		else $error("second stage item lost during a stall");

endmodule
